// File: rtl/bts_pkg.sv
package bts_pkg;

   // Field widths
   localparam int TIME_W    = 48;
   localparam int FLUX_W    = 24;
   localparam int WGT_W     = 24;
   localparam int SCORE_W   = 56;
   localparam int CSR_IDX_W = 2;

   // Accumulator widths
   localparam int RSUM_W = 40;
   localparam int SSUM_W = 56;
   localparam int WSUM_W = 64;

   // Arithmetic unit widths
   localparam int PROD_W = 2 * FLUX_W;
   localparam int NUM_W  = 128;
   localparam int DVS_W  = 80;
   localparam int CNT_W  = 7;

   // Last count of each iterating step
   localparam logic [CNT_W-1:0] FOLD_LAST = 7'd47;
   localparam logic [CNT_W-1:0] PROD_LAST = 7'd3;
   localparam logic [CNT_W-1:0] SQR_LAST  = 7'd55;
   localparam logic [CNT_W-1:0] DEN_LAST  = 7'd39;
   localparam logic [CNT_W-1:0] DIV_LAST  = 7'd127;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DURATION = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET   = 2'd2;

   localparam logic [TIME_W-1:0]  PERIOD_RESET = 48'd65536;
   localparam logic [RSUM_W-1:0]  ONE_Q24      = 40'h00_0100_0000;
   localparam logic [SCORE_W-1:0] S56_MAX      = 56'h7F_FFFF_FFFF_FFFF;
   localparam logic [SCORE_W-1:0] S56_MIN      = 56'h80_0000_0000_0000;

   typedef enum logic [1:0] {
      PROD_FSQ,
      PROD_MAG,
      PROD_HI,
      PROD_LO
   } bts_prod_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FOLD,
      ST_PROD,
      ST_ACC,
      ST_SQR_LOAD,
      ST_SQR,
      ST_DEN_LOAD,
      ST_DEN,
      ST_DIV_LOAD,
      ST_DIV,
      ST_FIN
   } bts_state_type;

   typedef struct packed {
      logic             take;
      logic             div_step;
      logic             prod_step;
      bts_prod_sel_type prod_sel;
      logic             acc;
      logic             sqr_load;
      logic             mul_step;
      logic             den_load;
      logic             div_load;
      logic             finish;
   } bts_cmd_type;

endpackage

// File: rtl/bts_if.sv
interface bts_req_if;
   import bts_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [TIME_W-1:0]        sample_time;
   logic signed [FLUX_W-1:0] flux_value;
   logic [WGT_W-1:0]         sample_weight;
   logic                     last_sample;

   modport source (output valid, sample_time, flux_value, sample_weight, last_sample,
                   input ready);
   modport sink (input valid, sample_time, flux_value, sample_weight, last_sample,
                 output ready);
endinterface

interface bts_rsp_if;
   import bts_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [SCORE_W-1:0] score;
   logic                      degenerate;

   modport source (output valid, score, degenerate, input ready);
   modport sink (input valid, score, degenerate, output ready);
endinterface

interface bts_csr_if;
   import bts_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [TIME_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/bts_ctrl.sv
module bts_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic                 smp_last,
   output bts_pkg::bts_cmd_type cmd
);
   import bts_pkg::*;

   bts_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign out_free = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_FOLD;
         ST_FOLD:     if (cnt_ff == FOLD_LAST) state_in = ST_PROD;
         ST_PROD:     if (cnt_ff == PROD_LAST) state_in = ST_ACC;
         ST_ACC:      state_in = smp_last ? ST_SQR_LOAD : ST_IDLE;
         ST_SQR_LOAD: state_in = ST_SQR;
         ST_SQR:      if (cnt_ff == SQR_LAST) state_in = ST_DEN_LOAD;
         ST_DEN_LOAD: state_in = ST_DEN;
         ST_DEN:      if (cnt_ff == DEN_LAST) state_in = ST_DIV_LOAD;
         ST_DIV_LOAD: state_in = ST_DIV;
         ST_DIV:      if (cnt_ff == DIV_LAST) state_in = ST_FIN;
         ST_FIN:      if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // restart the step count on every state change
   always_comb begin
      cnt_in = (state_in == state_ff) ? cnt_ff + 1'b1 : '0;
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         ST_FOLD:     cmd.div_step = 1'b1;
         ST_PROD: begin
            cmd.prod_step = 1'b1;
            cmd.prod_sel  = bts_prod_sel_type'(cnt_ff[1:0]);
         end
         ST_ACC:      cmd.acc      = 1'b1;
         ST_SQR_LOAD: cmd.sqr_load = 1'b1;
         ST_SQR:      cmd.mul_step = 1'b1;
         ST_DEN_LOAD: cmd.den_load = 1'b1;
         ST_DEN:      cmd.mul_step = 1'b1;
         ST_DIV_LOAD: cmd.div_load = 1'b1;
         ST_DIV:      cmd.div_step = 1'b1;
         ST_FIN:      cmd.finish   = out_free;
         default:     cmd          = '0;
      endcase
   end

   assign rsp_valid_in = cmd.finish | (rsp_valid_ff & ~rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/bts_dp.sv
module bts_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  bts_pkg::bts_cmd_type              cmd,
   output logic                              smp_last,
   input  logic [bts_pkg::TIME_W-1:0]        sample_time,
   input  logic signed [bts_pkg::FLUX_W-1:0] flux_value,
   input  logic [bts_pkg::WGT_W-1:0]         sample_weight,
   input  logic                              last_sample,
   input  logic                              csr_write,
   input  logic [bts_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bts_pkg::TIME_W-1:0]        csr_data,
   output logic signed [bts_pkg::SCORE_W-1:0] score,
   output logic                              degenerate
);
   import bts_pkg::*;

   function automatic logic [SCORE_W-1:0] sat_pos(input logic [WSUM_W-1:0] v);
      sat_pos = (v > {8'd0, S56_MAX}) ? S56_MAX : v[SCORE_W-1:0];
   endfunction

   // configuration
   logic [TIME_W-1:0] period_ff, duration_ff, offset_ff;

   // captured sample
   logic [TIME_W-1:0] time_ff;
   logic [FLUX_W-1:0] fabs_ff;
   logic              fneg_ff;
   logic [WGT_W-1:0]  wgt_ff;
   logic              last_ff;

   // shared restoring divider
   logic [DVS_W-1:0] rem_ff, dvs_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [DVS_W:0]   div_sh;
   logic [DVS_W+1:0] div_dif;
   logic             div_ge;

   // per-sample products
   logic [TIME_W-1:0] fold_m;
   logic              transit, transit_ff;
   logic [FLUX_W-1:0] op_a, op_b;
   logic [PROD_W-1:0] prod;
   logic [PROD_W-1:0] f2_ff, mag_ff, ph_ff, pl_ff;

   // sums
   logic [RSUM_W-1:0]        rsum_ff;
   logic signed [SSUM_W-1:0] ssum_ff;
   logic [WSUM_W-1:0]        wsum_ff;
   logic [WSUM_W:0]          wsum_add;
   logic [PROD_W:0]          mag_rnd;
   logic [SSUM_W+1:0]        flux_term, ssum_add;
   logic [SSUM_W-1:0]        ssum_sat;
   logic [RSUM_W:0]          rsum_add;

   // shift-add multiplier
   logic [NUM_W-1:0]   acc_ff, ma_ff;
   logic [SSUM_W-1:0]  mb_ff;
   logic [SSUM_W-1:0]  sabs;
   logic [RSUM_W-1:0]  rdist;

   // final score
   logic               degen, below;
   logic [NUM_W:0]     w_minus_q, q_minus_w, w_plus_q;
   logic [SCORE_W-1:0] neg_d, score_sel;
   logic [SCORE_W-1:0] score_ff;
   logic               degen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff   <= PERIOD_RESET;
         duration_ff <= '0;
         offset_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_PERIOD:   period_ff   <= csr_data;
            REG_DURATION: duration_ff <= csr_data;
            REG_OFFSET:   offset_ff   <= csr_data;
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         time_ff <= sample_time;
         fneg_ff <= flux_value[FLUX_W-1];
         fabs_ff <= flux_value[FLUX_W-1] ? (~flux_value + 1'b1) : flux_value;
         wgt_ff  <= sample_weight;
         last_ff <= last_sample;
      end
   end

   assign smp_last = last_ff;

   // one quotient bit per step; the dividend shifts out of quo_ff as the quotient shifts in
   assign div_sh  = {rem_ff, quo_ff[NUM_W-1]};
   assign div_dif = {1'b0, div_sh} - {2'b0, dvs_ff};
   assign div_ge  = ~div_dif[DVS_W+1];

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         rem_ff <= '0;
         quo_ff <= {sample_time, {(NUM_W-TIME_W){1'b0}}};
         dvs_ff <= {{(DVS_W-TIME_W){1'b0}}, period_ff};
      end else if (cmd.den_load) begin
         quo_ff <= {acc_ff[NUM_W-17:0], 16'd0};
      end else if (cmd.div_load) begin
         rem_ff <= '0;
         dvs_ff <= acc_ff[DVS_W-1:0];
      end else if (cmd.div_step) begin
         rem_ff <= div_ge ? div_dif[DVS_W-1:0] : div_sh[DVS_W-1:0];
         quo_ff <= {quo_ff[NUM_W-2:0], div_ge};
      end
   end

   // a zero period leaves the time unfolded
   assign fold_m  = (period_ff == '0) ? time_ff : rem_ff[TIME_W-1:0];
   assign transit = (fold_m >= offset_ff) && ((fold_m - offset_ff) <= duration_ff);

   always_comb begin
      case (cmd.prod_sel)
         PROD_FSQ: begin
            op_a = fabs_ff;
            op_b = fabs_ff;
         end
         PROD_MAG: begin
            op_a = fabs_ff;
            op_b = wgt_ff;
         end
         PROD_HI: begin
            op_a = f2_ff[PROD_W-1:FLUX_W];
            op_b = wgt_ff;
         end
         PROD_LO: begin
            op_a = f2_ff[FLUX_W-1:0];
            op_b = wgt_ff;
         end
         default: begin
            op_a = fabs_ff;
            op_b = fabs_ff;
         end
      endcase
   end

   assign prod = op_a * op_b;

   always_ff @(posedge clock) begin
      if (cmd.prod_step) begin
         case (cmd.prod_sel)
            PROD_FSQ: begin
               f2_ff      <= prod;
               transit_ff <= transit;
            end
            PROD_MAG: mag_ff <= prod;
            PROD_HI:  ph_ff  <= prod;
            PROD_LO:  pl_ff  <= prod;
            default:  ;
         endcase
      end
   end

   // floor(w*f^2 / 2^24) split into high and low halves of f^2
   assign wsum_add = {1'b0, wsum_ff} + {{(WSUM_W-PROD_W+1){1'b0}}, ph_ff}
                   + {{(WSUM_W-FLUX_W+1){1'b0}}, pl_ff[PROD_W-1:FLUX_W]};

   // negative terms round toward minus infinity
   assign mag_rnd   = fneg_ff ? ({1'b0, mag_ff} + 8'd255) : {1'b0, mag_ff};
   assign flux_term = fneg_ff ? -{{(SSUM_W+1-PROD_W+8){1'b0}}, mag_rnd[PROD_W:8]}
                              :  {{(SSUM_W+1-PROD_W+8){1'b0}}, mag_rnd[PROD_W:8]};
   assign ssum_add  = {{2{ssum_ff[SSUM_W-1]}}, ssum_ff} + flux_term;

   always_comb begin
      if (ssum_add[SSUM_W+1:SSUM_W-1] == 3'b000 || ssum_add[SSUM_W+1:SSUM_W-1] == 3'b111) begin
         ssum_sat = ssum_add[SSUM_W-1:0];
      end else begin
         ssum_sat = ssum_add[SSUM_W+1] ? S56_MIN : S56_MAX;
      end
   end

   assign rsum_add = {1'b0, rsum_ff} + {{(RSUM_W-WGT_W+1){1'b0}}, wgt_ff};

   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         rsum_ff <= '0;
         ssum_ff <= '0;
         wsum_ff <= '0;
      end else if (cmd.acc) begin
         wsum_ff <= wsum_add[WSUM_W] ? '1 : wsum_add[WSUM_W-1:0];
         if (transit_ff) begin
            ssum_ff <= ssum_sat;
            rsum_ff <= rsum_add[RSUM_W] ? '1 : rsum_add[RSUM_W-1:0];
         end
      end
   end

   assign sabs  = ssum_ff[SSUM_W-1] ? (~ssum_ff + 1'b1) : ssum_ff;
   assign rdist = (rsum_ff < ONE_Q24) ? (ONE_Q24 - rsum_ff) : (rsum_ff - ONE_Q24);

   always_ff @(posedge clock) begin
      if (cmd.sqr_load) begin
         acc_ff <= '0;
         ma_ff  <= {{(NUM_W-SSUM_W){1'b0}}, sabs};
         mb_ff  <= sabs;
      end else if (cmd.den_load) begin
         acc_ff <= '0;
         ma_ff  <= {{(NUM_W-RSUM_W){1'b0}}, rsum_ff};
         mb_ff  <= {{(SSUM_W-RSUM_W){1'b0}}, rdist};
      end else if (cmd.mul_step) begin
         if (mb_ff[0]) acc_ff <= acc_ff + ma_ff;
         ma_ff <= {ma_ff[NUM_W-2:0], 1'b0};
         mb_ff <= {1'b0, mb_ff[SSUM_W-1:1]};
      end
   end

   assign degen     = (rsum_ff == '0) || (rsum_ff == ONE_Q24);
   assign below     = rsum_ff < ONE_Q24;
   assign w_minus_q = {{(NUM_W-WSUM_W+1){1'b0}}, wsum_ff} - {1'b0, quo_ff};
   assign q_minus_w = {1'b0, quo_ff} - {{(NUM_W-WSUM_W+1){1'b0}}, wsum_ff};
   assign w_plus_q  = {{(NUM_W-WSUM_W+1){1'b0}}, wsum_ff} + {1'b0, quo_ff};
   assign neg_d     = ~q_minus_w[SCORE_W-1:0] + 1'b1;

   always_comb begin
      if (degen) begin
         score_sel = sat_pos(wsum_ff);
      end else if (below) begin
         if (!w_minus_q[NUM_W]) begin
            score_sel = sat_pos(w_minus_q[WSUM_W-1:0]);
         end else if (q_minus_w[NUM_W:SCORE_W] != '0 ||
                      q_minus_w[SCORE_W-1:0] > S56_MIN) begin
            score_sel = S56_MIN;
         end else begin
            score_sel = neg_d;
         end
      end else begin
         if (w_plus_q[NUM_W:WSUM_W] != '0) begin
            score_sel = S56_MAX;
         end else begin
            score_sel = sat_pos(w_plus_q[WSUM_W-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         score_ff <= score_sel;
         degen_ff <= degen;
      end
   end

   assign score      = score_ff;
   assign degenerate = degen_ff;

endmodule

// File: rtl/bls_transit_score_top.sv
// Box least squares transit score for one trial period, duration and phase offset.
// Light-curve samples (time Q32.16, flux Q8.16, weight Q0.24) arrive one transaction
// at a time on req_bus; each sample is folded by the period and, when its phase lies
// in the box, adds to the in-transit weight and flux sums, while every sample adds
// to the weighted squared flux sum. A sample with last_sample set produces one
// rsp_bus transaction carrying score = wx - s^2/(r(1-r)) in Q24.32, saturated, and
// the degenerate flag (in-transit weight exactly 0 or 1.0, score then wx); the sums
// then clear for the next light curve. A sample that is not last passes through
// these steps in order: accept, the time-modulo-period fold on the shared
// restoring divider (one quotient bit per cycle), four products on the shared 24x24
// multiplier, and accumulate. A last sample then goes on to load and run the
// bit-serial multiplications for s^2 and r(1-r), load and run the divider for
// the quotient, and register the final score in its finish step. The result sits
// in an output register, so the next sample is taken while it waits to be read;
// a following last sample holds in its finish step until that register frees up.
// Configuration registers (0 period, 1 duration, 2 offset) take a write every
// cycle and are only to be changed while the block is idle.
module bls_transit_score_top (
   input logic        clock,
   input logic        reset,
   bts_req_if.sink    req_bus,
   bts_rsp_if.source  rsp_bus,
   bts_csr_if.sink    csr_bus
);
   import bts_pkg::*;

   bts_cmd_type cmd;
   logic        smp_last;

   // configuration writes are never back-pressured
   assign csr_bus.ready = 1'b1;

   bts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .smp_last  (smp_last),
      .cmd       (cmd)
   );

   bts_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .smp_last      (smp_last),
      .sample_time   (req_bus.sample_time),
      .flux_value    (req_bus.flux_value),
      .sample_weight (req_bus.sample_weight),
      .last_sample   (req_bus.last_sample),
      .csr_write     (csr_bus.valid),
      .csr_index     (csr_bus.index),
      .csr_data      (csr_bus.data),
      .score         (rsp_bus.score),
      .degenerate    (rsp_bus.degenerate)
   );

endmodule

// File: verif/bls_transit_score_top_tb.sv
`timescale 1ns / 100ps

module bls_transit_score_top_tb;
   import bts_pkg::*;

   localparam int RESET_CYCLES  = 7;
   // A last sample keeps the block busy through its multiplications and division after it is taken.
   localparam int SETTLE_CYCLES = 300;
   localparam int QUIET_LIMIT   = 20000;
   localparam int HOLD_CYCLES   = 1500;
   localparam int RANDOM_ITEMS  = 1500;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam logic [TIME_W-1:0]    TIME_MAX   = '1;

   // Saturation bounds of the flux sum and of the score, widened for compares
   localparam logic signed [63:0]  SSUM_CEIL   = 64'(S56_MAX);
   localparam logic signed [63:0]  SSUM_FLOOR  = -SSUM_CEIL - 1;
   localparam logic signed [129:0] SCORE_CEIL  = 130'(S56_MAX);
   localparam logic signed [129:0] SCORE_FLOOR = -SCORE_CEIL - 1;

   typedef struct {
      logic [TIME_W-1:0]        sample_time;
      logic signed [FLUX_W-1:0] flux;
      logic [WGT_W-1:0]         weight;
      logic                     last;
   } sample_type;

   typedef struct {
      logic signed [SCORE_W-1:0] score;
      logic                      degenerate;
   } score_rec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bts_req_if req_bus ();
   bts_rsp_if rsp_bus ();
   bts_csr_if csr_bus ();

   bls_transit_score_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Box settings as the block should hold them, and the three running sums
   logic [TIME_W-1:0]        box_period   = PERIOD_RESET;
   logic [TIME_W-1:0]        box_duration = '0;
   logic [TIME_W-1:0]        box_offset   = '0;
   logic [RSUM_W-1:0]        r_sum        = '0;
   logic signed [SSUM_W-1:0] s_sum        = '0;
   logic [WSUM_W-1:0]        wx_sum       = '0;

   score_rec_type expected_scores[$];
   int unsigned   mismatch_count  = 0;
   bit            pacing_on       = 1'b0;
   int unsigned   rsp_hold_cycles = 0;

   always #1 clock = ~clock;

   // Append one expected score behind the ones already waiting
   function automatic void queue_expected(input score_rec_type rec);
      expected_scores.insert(expected_scores.size(), rec);
   endfunction

   // Fold one accepted sample into the sums; on a last sample, queue the score
   // it must produce and clear the sums for the next light curve.
   function automatic void accumulate_sample(input sample_type smp);
      logic [TIME_W-1:0]   phase;
      logic [FLUX_W-1:0]   f_mag;
      logic [PROD_W-1:0]   f_sq;
      logic [71:0]         wsq;
      logic [WSUM_W:0]     wx_next;
      logic [PROD_W-1:0]   wf_mag;
      logic [63:0]         s_mag_term;
      logic signed [63:0]  s_term;
      logic signed [63:0]  s_next;
      logic [RSUM_W:0]     r_next;
      logic [SSUM_W-1:0]   s_abs;
      logic [127:0]        num;
      logic [127:0]        den;
      logic [127:0]        quo;
      logic signed [129:0] total;
      score_rec_type       rec;

      // A zero period leaves the time unfolded
      phase = (box_period != '0) ? smp.sample_time % box_period : smp.sample_time;
      f_mag = smp.flux;
      if (smp.flux[FLUX_W-1]) f_mag = ~f_mag + 1'b1;

      // Every sample adds floor(w * f^2 / 2^24) to the squared flux sum
      f_sq    = PROD_W'(f_mag) * PROD_W'(f_mag);
      wsq     = 72'(f_sq) * 72'(smp.weight);
      wx_next = {1'b0, wx_sum} + 65'(wsq >> 24);
      wx_sum  = wx_next[WSUM_W] ? '1 : wx_next[WSUM_W-1:0];

      // Inside the box (both edges inclusive) add floor(w * f / 2^8) and w
      if (phase >= box_offset && phase - box_offset <= box_duration) begin
         wf_mag = PROD_W'(f_mag) * PROD_W'(smp.weight);
         if (smp.flux[FLUX_W-1]) begin
            s_mag_term = (64'(wf_mag) + 64'd255) >> 8;
            s_term     = -$signed(s_mag_term);
         end else begin
            s_term = $signed(64'(wf_mag) >> 8);
         end
         s_next = 64'(s_sum) + s_term;
         if (s_next > SSUM_CEIL) s_sum = S56_MAX;
         else if (s_next < SSUM_FLOOR) s_sum = S56_MIN;
         else s_sum = s_next[SSUM_W-1:0];
         r_next = {1'b0, r_sum} + (RSUM_W+1)'(smp.weight);
         r_sum  = r_next[RSUM_W] ? '1 : r_next[RSUM_W-1:0];
      end

      if (smp.last) begin
         // With r at exactly 0 or 1.0 the quotient drops out and wx stands alone
         quo = '0;
         rec.degenerate = (r_sum == '0 || r_sum == ONE_Q24);
         if (!rec.degenerate) begin
            s_abs = s_sum;
            if (s_sum < 0) s_abs = ~s_abs + 1'b1;
            num = 128'(s_abs) * 128'(s_abs);
            num = num << 16;
            den = (r_sum < ONE_Q24) ? 128'(r_sum) * 128'(ONE_Q24 - r_sum)
                                    : 128'(r_sum) * 128'(r_sum - ONE_Q24);
            quo = num / den;
         end
         // Above 1.0 the box weight flips the sign of r(1-r), so add instead
         if (r_sum < ONE_Q24) total = $signed(130'(wx_sum)) - $signed(130'(quo));
         else total = $signed(130'(wx_sum)) + $signed(130'(quo));
         if (total > SCORE_CEIL) rec.score = S56_MAX;
         else if (total < SCORE_FLOOR) rec.score = S56_MIN;
         else rec.score = total[SCORE_W-1:0];
         queue_expected(rec);
         r_sum  = '0;
         s_sum  = '0;
         wx_sum = '0;
      end
   endfunction

   // Mostly back to back, some short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (!pacing_on) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 120);
   endfunction

   function automatic logic [TIME_W-1:0] rand_time();
      return TIME_W'({$urandom, $urandom});
   endfunction

   function automatic sample_type light_sample(input logic [TIME_W-1:0] t,
                                               input logic signed [FLUX_W-1:0] f,
                                               input logic [WGT_W-1:0] w,
                                               input logic last);
      sample_type smp;
      smp.sample_time = t;
      smp.flux        = f;
      smp.weight      = w;
      smp.last        = last;
      return smp;
   endfunction

   // Curve styles: 0-5 normalized weights and flux near zero, 6-7 normalized
   // weights with full-range flux, 8 full-range everything, 9 sparse weights.
   function automatic sample_type random_sample(input int unsigned style,
                                                input int unsigned len,
                                                input logic last);
      sample_type  smp;
      int unsigned wcap;
      wcap = (2 * 32'h100_0000) / len;
      if (wcap > 32'hFF_FFFF) wcap = 32'hFF_FFFF;
      smp.sample_time = rand_time();
      smp.last        = last;
      if (style < 8) smp.weight = WGT_W'($urandom_range(0, wcap));
      else if (style == 8) smp.weight = WGT_W'($urandom);
      else smp.weight = ($urandom_range(0, 3) == 0) ? WGT_W'($urandom_range(0, 255)) : '0;
      if (style < 6 || style == 9)
         smp.flux = FLUX_W'(int'($urandom_range(0, 131072)) - 65536);
      else smp.flux = FLUX_W'($urandom);
      return smp;
   endfunction

   // Offer one sample, hold it until taken, then maybe drop valid for a gap.
   // With no gap, valid stays up so the next sample follows without a gap.
   task automatic send_sample(input sample_type smp);
      int unsigned gap;
      req_bus.valid         <= 1'b1;
      req_bus.sample_time   <= smp.sample_time;
      req_bus.flux_value    <= smp.flux;
      req_bus.sample_weight <= smp.weight;
      req_bus.last_sample   <= smp.last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      accumulate_sample(smp);
      gap = pick_gap();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Leaves csr valid high; the caller drops it after its last write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [TIME_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         REG_PERIOD:   box_period   = value;
         REG_DURATION: box_duration = value;
         REG_OFFSET:   box_offset   = value;
         default: ;
      endcase
   endtask

   task automatic set_box(input logic [TIME_W-1:0] period, duration, offset);
      write_reg(REG_PERIOD, period);
      write_reg(REG_DURATION, duration);
      write_reg(REG_OFFSET, offset);
      csr_bus.valid <= 1'b0;
   endtask

   // Stop offering, let every queued score come back, then give the block
   // time to finish any sample that produces no result.
   task automatic wait_for_scores();
      req_bus.valid <= 1'b0;
      while (expected_scores.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Reset box: period 1.0, zero duration, zero offset
   task automatic test_reset_defaults();
      pacing_on = 1'b1;
      // two half weights both fold onto phase 0: in-transit weight is exactly 1.0
      send_sample(light_sample('0, 24'sh7F_FFFF, 24'h80_0000, 1'b0));
      send_sample(light_sample(48'h1_0000, 24'sh80_0000, 24'h80_0000, 1'b1));
      // phase one step past a zero-length box: nothing in transit
      send_sample(light_sample(48'h1, 24'sh01_0000, 24'hFF_FFFF, 1'b1));
      wait_for_scores();
   endtask

   task automatic test_box_extremes();
      // full period and full duration: every sample is in transit
      set_box(TIME_MAX, TIME_MAX, '0);
      // weight just above 1.0 with peak flux: score saturates high
      send_sample(light_sample('0, 24'sh7F_FFFF, 24'h80_0001, 1'b0));
      send_sample(light_sample(TIME_MAX, 24'sh7F_FFFF, 24'h80_0000, 1'b1));
      // weight just below 1.0 with most negative flux: score saturates low
      send_sample(light_sample(TIME_MAX, 24'sh80_0000, 24'h80_0000, 1'b0));
      send_sample(light_sample('0, 24'sh80_0000, 24'h7F_FFFF, 1'b1));
      // ordinary mixed-sign curve
      send_sample(light_sample(48'hAAAA_5555_AAAA, 24'sh00_C000, 24'h40_0000, 1'b0));
      send_sample(light_sample(48'h5555_AAAA_5555, 24'shFF_8000, 24'h20_0000, 1'b1));
      wait_for_scores();
      // offset beyond any folded phase keeps the box empty
      set_box(PERIOD_RESET, '0, TIME_MAX);
      send_sample(light_sample(48'h1234_0000_0000, 24'sh01_0000, 24'h80_0000, 1'b1));
      wait_for_scores();
   endtask

   task automatic test_zero_period();
      // zero period: phase is the raw time; probe both box edges and one step outside each
      set_box('0, 48'h10_0000, 48'h8_0000);
      send_sample(light_sample(48'h8_0000, 24'sh01_8000, 24'h30_0000, 1'b0));
      send_sample(light_sample(48'h18_0000, 24'shFE_8000, 24'h30_0000, 1'b0));
      send_sample(light_sample(48'h7_FFFF, 24'sh02_0000, 24'h20_0000, 1'b0));
      send_sample(light_sample(48'h18_0001, 24'sh03_0000, 24'h20_0000, 1'b1));
      wait_for_scores();
   endtask

   task automatic test_unused_index();
      // a write past the last register must leave the box alone
      write_reg(REG_UNUSED, TIME_MAX);
      csr_bus.valid <= 1'b0;
      send_sample(light_sample(48'h10_0000, 24'sh01_0000, 24'h10_0000, 1'b1));
      wait_for_scores();
   endtask

   task automatic test_output_backpressure();
      int unsigned c;
      set_box(48'h4_0000, 48'h2_0000, 48'h1_0000);
      pacing_on       = 1'b0;
      // the result side holds off long enough for the output register and the
      // next last sample to back up and stall the input
      rsp_hold_cycles = HOLD_CYCLES;
      for (c = 0; c < 4; c++) begin
         send_sample(light_sample(rand_time(), 24'sh00_8000, 24'h40_0000, 1'b0));
         send_sample(light_sample(rand_time(), -24'sh00_4000, 24'h60_0000, 1'b1));
      end
      wait_for_scores();
   endtask

   task automatic random_box();
      logic [TIME_W-1:0] p;
      logic [TIME_W-1:0] d;
      logic [TIME_W-1:0] o;
      case ($urandom_range(0, 3))
         0, 1: begin
            // realistic search grid point: period 1 to 1024 time units
            p = TIME_W'($urandom_range(32'h1_0000, 32'h400_0000));
            d = p / TIME_W'($urandom_range(2, 20));
            o = TIME_W'($urandom_range(0, 32'(p - 1'b1)));
         end
         2: begin
            p = rand_time();
            d = rand_time();
            o = rand_time();
         end
         default: begin
            case ($urandom_range(0, 3))
               0:       p = '0;
               1:       p = 48'd1;
               2:       p = TIME_MAX;
               default: p = PERIOD_RESET;
            endcase
            d = ($urandom_range(0, 1) != 0) ? TIME_MAX : '0;
            case ($urandom_range(0, 2))
               0:       o = '0;
               1:       o = TIME_MAX;
               default: o = rand_time();
            endcase
         end
      endcase
      set_box(p, d, o);
   endtask

   task automatic test_random_curves();
      int unsigned sent;
      int unsigned n;
      int unsigned k;
      int unsigned style;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         // some phases run without any idling on either side
         pacing_on = ($urandom_range(0, 3) != 0);
         random_box();
         repeat ($urandom_range(3, 8)) begin
            n     = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 30);
            style = $urandom_range(0, 9);
            for (k = 0; k < n; k++) send_sample(random_sample(style, n, k == n - 1));
            sent += n;
         end
         wait_for_scores();
      end
   endtask

   // Result side: accept at random, honor a requested long hold
   initial begin : result_sink
      int unsigned stall;
      rsp_bus.ready <= 1'b1;
      forever begin
         @(posedge clock);
         stall = 0;
         if (rsp_hold_cycles != 0) begin
            stall           = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else if ($urandom_range(0, 3) == 0) begin
            stall = pick_gap();
         end
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Compare each score transaction with the oldest queued expectation
   always @(posedge clock) begin : score_check
      score_rec_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_scores.size() == 0) begin
            $display("%0t: unexpected score %0d degenerate %0b", $time,
                     rsp_bus.score, rsp_bus.degenerate);
            mismatch_count++;
         end else begin
            want = expected_scores.pop_front();
            if (rsp_bus.score !== want.score) begin
               $display("%0t: score expected %0d actual %0d", $time,
                        want.score, rsp_bus.score);
               mismatch_count++;
            end
            if (rsp_bus.degenerate !== want.degenerate) begin
               $display("%0t: degenerate expected %0b actual %0b", $time,
                        want.degenerate, rsp_bus.degenerate);
               mismatch_count++;
            end
         end
      end
   end

   // End the run if no channel moves a transaction for too long
   initial begin : stall_watch
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      req_bus.valid         <= 1'b0;
      req_bus.sample_time   <= '0;
      req_bus.flux_value    <= '0;
      req_bus.sample_weight <= '0;
      req_bus.last_sample   <= 1'b0;
      csr_bus.valid         <= 1'b0;
      csr_bus.index         <= REG_PERIOD;
      csr_bus.data          <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_box_extremes();
      test_zero_period();
      test_unused_index();
      test_output_backpressure();
      test_random_curves();

      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/bts_pkg.sv
rtl/bts_if.sv
rtl/bts_ctrl.sv
rtl/bts_dp.sv
rtl/bls_transit_score_top.sv
verif/bls_transit_score_top_tb.sv
